FILE: hdl/lip_pkg.sv
// Package for the letter interval partitioner.
// Holds the sizes, the request and result structs and the internal buses.
// No dependencies.
`timescale 1ns / 1ps

package lip_pkg;

	localparam int ALPHABET = 26;
	localparam int LETTER_W = 5;
	localparam int MAX_LEN  = 65536;
	localparam int POS_W    = 16;
	localparam int CNT_W    = 17;
	localparam int LEN_W    = 17;
	localparam int IDX_W    = $clog2(ALPHABET);
	localparam int COUNT_W  = $clog2(ALPHABET + 1);

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                last_letter;
	} req_t;

	typedef struct packed {
		logic [LEN_W-1:0] part_length;
		logic             last_part;
		logic             overflow;
	} rsp_t;

	// Write side of the interval and order memories.
	typedef struct packed {
		logic             first_we;
		logic             final_we;
		logic [IDX_W-1:0] letter_addr;
		logic [POS_W-1:0] pos;
		logic             order_we;
		logic [IDX_W-1:0] order_addr;
	} mem_wr_t;

	// State of the string being collected, seen by the walk unit.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               overflow;
	} rec_status_t;

endpackage

FILE: hdl/letter_interval_partitioner.sv
// Top level of the letter interval partitioner.
// Depends on lip_pkg, lip_ram, lip_record and lip_walk.
`timescale 1ns / 1ps

//  Channel   Handshake               Payload        Direction
//  request   start / busy            req (req_t)    in
//  result    rsp_strobe (one cycle)  rsp (rsp_t)    out
//
// A letter is taken in every cycle while start is high and busy is low. The letter
// that ends the string starts a walk over the D distinct letters: the order memory
// and then the interval memories are read in a three-stage pipeline, and busy stays
// high until the walk ends. Up to D partition lengths are strobed out; the final one
// comes in the first cycle in which busy is low again. Reset clears the seen flags
// and counters at once; the memories hold no reset value and are only read where
// written. The receiver cannot stall.

module letter_interval_partitioner (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lip_pkg::req_t req,
	output logic          rsp_strobe,
	output lip_pkg::rsp_t rsp
);

	logic                        accept;
	logic                        go;
	logic                        clear;
	lip_pkg::mem_wr_t            wr;
	lip_pkg::rec_status_t        status;
	logic [lip_pkg::IDX_W-1:0]   order_raddr;
	logic [lip_pkg::IDX_W-1:0]   pos_raddr;
	logic [lip_pkg::IDX_W-1:0]   order_rdata;
	logic [lip_pkg::POS_W-1:0]   first_rdata;
	logic [lip_pkg::POS_W-1:0]   final_rdata;

	// A letter enters only while no walk is in progress.
	assign accept = start && !busy;

	// The recorder tracks positions and writes intervals as letters arrive.
	lip_record u_record (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.clear  (clear),
		.wr     (wr),
		.status (status),
		.go     (go)
	);

	// First position of each letter, written only on its first appearance.
	lip_ram #(
		.WIDTH (lip_pkg::POS_W),
		.DEPTH (lip_pkg::ALPHABET)
	) u_first_ram (
		.clk   (clk),
		.we    (wr.first_we),
		.waddr (wr.letter_addr),
		.wdata (wr.pos),
		.raddr (pos_raddr),
		.rdata (first_rdata)
	);

	// Last position of each letter, rewritten on every appearance.
	lip_ram #(
		.WIDTH (lip_pkg::POS_W),
		.DEPTH (lip_pkg::ALPHABET)
	) u_final_ram (
		.clk   (clk),
		.we    (wr.final_we),
		.waddr (wr.letter_addr),
		.wdata (wr.pos),
		.raddr (pos_raddr),
		.rdata (final_rdata)
	);

	// Letters in order of first appearance, which sorts intervals by start.
	lip_ram #(
		.WIDTH (lip_pkg::IDX_W),
		.DEPTH (lip_pkg::ALPHABET)
	) u_order_ram (
		.clk   (clk),
		.we    (wr.order_we),
		.waddr (wr.order_addr),
		.wdata (wr.letter_addr),
		.raddr (order_raddr),
		.rdata (order_rdata)
	);

	// The walk merges intervals and strobes one length per partition.
	lip_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.status      (status),
		.order_rdata (order_rdata),
		.first_rdata (first_rdata),
		.final_rdata (final_rdata),
		.order_raddr (order_raddr),
		.pos_raddr   (pos_raddr),
		.busy        (busy),
		.clear       (clear),
		.rsp_strobe  (rsp_strobe),
		.rsp         (rsp)
	);

endmodule

FILE: hdl/lip_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/lip_record.sv
// Letter recorder: position counter, seen flags, distinct count and the
// write side of the memories. Depends on lip_pkg.
`timescale 1ns / 1ps

module lip_record (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  lip_pkg::req_t        req,
	input  logic                 clear,
	output lip_pkg::mem_wr_t     wr,
	output lip_pkg::rec_status_t status,
	output logic                 go
);

	logic [lip_pkg::ALPHABET-1:0] seen_q;
	logic [lip_pkg::COUNT_W-1:0]  count_q;
	logic [lip_pkg::CNT_W-1:0]    pos_cnt_q;
	logic                         ovf_q;

	logic                        valid;
	logic                        is_new;
	logic                        sat;
	logic [lip_pkg::POS_W-1:0]   pos;
	logic [lip_pkg::IDX_W-1:0]   idx;
	logic [lip_pkg::COUNT_W-1:0] count_next;

	always_comb begin
		valid = (req.letter < lip_pkg::LETTER_W'(lip_pkg::ALPHABET));
		idx = req.letter[lip_pkg::IDX_W-1:0];
		is_new = valid && !seen_q[idx];
		sat = (pos_cnt_q >= lip_pkg::CNT_W'(lip_pkg::MAX_LEN));
		pos = sat ? lip_pkg::POS_W'(lip_pkg::MAX_LEN - 1) : pos_cnt_q[lip_pkg::POS_W-1:0];
		count_next = count_q;
		if (is_new && (count_q < lip_pkg::COUNT_W'(lip_pkg::ALPHABET))) begin
			count_next = count_q + lip_pkg::COUNT_W'(1);
		end
		wr.first_we = accept && is_new;
		wr.final_we = accept && valid;
		wr.letter_addr = idx;
		wr.pos = pos;
		wr.order_we = accept && is_new && (count_q < lip_pkg::COUNT_W'(lip_pkg::ALPHABET));
		wr.order_addr = count_q[lip_pkg::IDX_W-1:0];
		status.count = count_q;
		status.overflow = ovf_q;
		go = accept && req.last_letter && (count_next != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			count_q <= '0;
			pos_cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (clear || (accept && req.last_letter && (count_next == '0))) begin
			// An empty string clears at once; otherwise the walk ends the string.
			seen_q <= '0;
			count_q <= '0;
			pos_cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept && valid) begin
			seen_q[idx] <= 1'b1;
			count_q <= count_next;
			if (sat) begin
				ovf_q <= 1'b1;
			end else begin
				pos_cnt_q <= pos_cnt_q + lip_pkg::CNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/lip_walk.sv
// Interval walk: reads letters in order of first appearance, fetches their
// intervals, merges them and emits one result per partition. Depends on lip_pkg.
`timescale 1ns / 1ps

module lip_walk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  lip_pkg::rec_status_t        status,
	input  logic [lip_pkg::IDX_W-1:0]   order_rdata,
	input  logic [lip_pkg::POS_W-1:0]   first_rdata,
	input  logic [lip_pkg::POS_W-1:0]   final_rdata,
	output logic [lip_pkg::IDX_W-1:0]   order_raddr,
	output logic [lip_pkg::IDX_W-1:0]   pos_raddr,
	output logic                        busy,
	output logic                        clear,
	output logic                        rsp_strobe,
	output lip_pkg::rsp_t               rsp
);

	typedef enum logic [1:0] {
		W_IDLE,
		W_RUN,
		W_LAST
	} wstate_t;

	wstate_t                     state_q;
	logic [lip_pkg::COUNT_W-1:0] iss_q;
	logic                        v_s1, last_s1, head_s1;
	logic                        v_s2, last_s2, head_s2;
	logic [lip_pkg::POS_W-1:0]   lo_q, hi_q;
	logic                        strobe_q;
	lip_pkg::rsp_t               rsp_q;

	logic                        issue;
	logic [lip_pkg::LEN_W-1:0]   cur_len;

	always_comb begin
		issue = (state_q == W_RUN) && (iss_q < status.count);
		order_raddr = iss_q[lip_pkg::IDX_W-1:0];
		pos_raddr = order_rdata;
		busy = (state_q != W_IDLE);
		clear = (state_q == W_LAST);
		cur_len = lip_pkg::LEN_W'(hi_q) - lip_pkg::LEN_W'(lo_q) + lip_pkg::LEN_W'(1);
		rsp_strobe = strobe_q;
		rsp = rsp_q;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (head_s2) begin
				lo_q <= first_rdata;
				hi_q <= final_rdata;
			end else if (first_rdata <= hi_q) begin
				if (final_rdata > hi_q) begin
					hi_q <= final_rdata;
				end
			end else begin
				lo_q <= first_rdata;
				hi_q <= final_rdata;
			end
		end
		rsp_q.part_length <= cur_len;
		rsp_q.last_part <= (state_q == W_LAST);
		rsp_q.overflow <= status.overflow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			iss_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			head_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			head_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			last_s1 <= issue && (iss_q == status.count - lip_pkg::COUNT_W'(1));
			head_s1 <= issue && (iss_q == '0);
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			head_s2 <= head_s1;
			if (issue) begin
				iss_q <= iss_q + lip_pkg::COUNT_W'(1);
			end
			// A gap before the next interval closes the current partition, and
			// the final state closes the last one.
			strobe_q <= (v_s2 && !head_s2 && (first_rdata > hi_q)) || (state_q == W_LAST);
			case (state_q)
				W_IDLE: begin
					iss_q <= '0;
					if (go) begin
						state_q <= W_RUN;
					end
				end
				W_RUN: begin
					if (v_s2 && last_s2) begin
						state_q <= W_LAST;
					end
				end
				W_LAST: begin
					state_q <= W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule
